[hw/rtl/smx_pkg.sv]
// ----------------------------------------------------------------------------
// smx_pkg: shared constants and functions
// Widths and the exponential table builder for the softmax block.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int unsigned SumWidth   = 22;
   localparam logic [15:0] Log2eQ15   = 16'd47274;

   // 2^(-1/2^j) in Q0.30, j = 1..10; entry 0 is unused.
   localparam logic [29:0] RootQ30 [0:10] = '{
      30'd0, 30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
      30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
      30'd1072289173, 30'd1073015252
   };

   // Table entry 2^(-idx/2^tb) in Q1.15; used to fill the exponential table.
   function automatic logic [15:0] exp_entry(input int unsigned idx,
                                             input int unsigned tb);
      logic [63:0] acc;
      acc = 64'd1073741824;
      for (int b = 9; b >= 0; b--) begin
         if (b < int'(tb) && idx[b]) begin
            acc = (acc * {34'd0, RootQ30[tb - b]} + 64'd536870912) >> 30;
         end
      end
      acc = (acc + 64'd16384) >> 15;
      return acc[15:0];
   endfunction

endpackage

[hw/rtl/softmax_vector.sv]
// ----------------------------------------------------------------------------
// softmax_vector: streamed numerically stable softmax
// Stores a vector, then emits exp(x - max) / sum for each element.
// ----------------------------------------------------------------------------
// Loading: one request per cycle until the request with tlast.
// After tlast, an exp pass fills the exp memory and the sum, then a divide
// pass (bit-serial divider) yields one element at a time, waiting out any
// output stall; no request is taken until the vector has drained.
// Reset is synchronous; it clears count, maximum, sum and control state.
// Element and exponential memories are not cleared.
module softmax_vector #(
   parameter int unsigned VEC_MAX        = 64,
   parameter int unsigned EXP_TABLE_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic        req_tlast,   // end_of_vector
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] probability
   output logic        rsp_tlast    // final_flag
);
   import smx_pkg::*;

   localparam int unsigned AddrWidth = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
   localparam int unsigned CntWidth  = $clog2(VEC_MAX + 1);

   typedef enum logic [2:0] {
      ST_LOAD, ST_EXP, ST_EXP_DRAIN, ST_RD, ST_DIV_START, ST_DIV_WAIT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [CntWidth-1:0]  count_ff, count_in;
   logic signed [15:0]   max_ff, max_in;
   logic [SumWidth-1:0]  sum_ff, sum_in;
   logic [CntWidth-1:0]  ptr_ff, ptr_in;
   logic [2:0]           pipe_ff, pipe_in;
   logic [AddrWidth-1:0] waddr0_ff, waddr0_in, waddr1_ff, waddr1_in;
   logic [AddrWidth-1:0] waddr2_ff, waddr2_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_last_ff, out_last_in;
   logic [15:0]          out_data_ff, out_data_in;

   logic [15:0] elem_mem [VEC_MAX];
   logic [15:0] exp_mem  [VEC_MAX];
   logic [15:0] elem_rd_ff, exp_rd_ff;
   logic        elem_we, exp_we;
   logic [AddrWidth-1:0] rd_addr;
   logic [15:0] diff, exp_val, quot;
   logic        div_start, div_done, req_fire;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign elem_we    = req_fire && (count_ff < CntWidth'(VEC_MAX));
   assign rd_addr    = ptr_ff[AddrWidth-1:0];
   assign exp_we     = pipe_ff[2];
   assign diff       = 16'(max_ff - $signed(elem_rd_ff));
   assign div_start  = (state_ff == ST_DIV_START);

   always_ff @(posedge clock) begin
      if (elem_we) elem_mem[count_ff[AddrWidth-1:0]] <= req_tdata;
      if (exp_we)  exp_mem[waddr2_ff] <= exp_val;
      elem_rd_ff <= elem_mem[rd_addr];
      exp_rd_ff  <= exp_mem[rd_addr];
   end

   smx_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
      .clock(clock), .diff(diff), .exp_q15(exp_val)
   );

   smx_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(exp_rd_ff),
      .denom(sum_ff), .done(div_done), .quot(quot)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      ptr_in       = ptr_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      // Exp pipeline: read (1), product (2), lookup (3), then write back.
      pipe_in   = {pipe_ff[1:0], 1'b0};
      waddr0_in = rd_addr;
      waddr1_in = waddr0_ff;
      waddr2_in = waddr1_ff;
      if (exp_we) sum_in = sum_ff + SumWidth'(exp_val);
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (elem_we) begin
                  count_in = count_ff + CntWidth'(1);
                  if ($signed(req_tdata) > max_ff) max_in = $signed(req_tdata);
               end
               if (req_tlast) begin
                  ptr_in   = '0;
                  sum_in   = '0;
                  state_in = ST_EXP;
                  if (count_in == '0) begin
                     max_in   = 16'sh8000;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_EXP: begin
            pipe_in[0] = 1'b1;
            ptr_in = ptr_ff + CntWidth'(1);
            if (ptr_in == count_ff) state_in = ST_EXP_DRAIN;
         end
         ST_EXP_DRAIN: begin
            ptr_in = '0;
            if (pipe_ff == 3'd0) state_in = ST_RD;
         end
         ST_RD: state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               out_valid_in = 1'b1;
               out_data_in  = quot;
               out_last_in  = (ptr_ff + CntWidth'(1) == count_ff);
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0;
               ptr_in = ptr_ff + CntWidth'(1);
               if (out_last_ff) begin
                  count_in = '0;
                  max_in   = 16'sh8000;
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         max_ff       <= 16'sh8000;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         pipe_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         pipe_ff      <= pipe_in;
         out_valid_ff <= out_valid_in;
      end
      waddr0_ff   <= waddr0_in;
      waddr1_ff   <= waddr1_in;
      waddr2_ff   <= waddr2_in;
      out_last_ff <= out_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule

[hw/rtl/smx_exp.sv]
// ----------------------------------------------------------------------------
// smx_exp: exponential unit
// Two-stage pipeline: d*log2(e) product, then table lookup and shift.
// ----------------------------------------------------------------------------
module smx_exp #(
   parameter int unsigned EXP_TABLE_BITS = 6
) (
   input  logic        clock,
   input  logic [15:0] diff,
   output logic [15:0] exp_q15
);
   import smx_pkg::*;

   localparam int unsigned TableDepth = 1 << EXP_TABLE_BITS;

   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic [15:0] exp_ff;
   logic [15:0] exp_in;
   logic [24:0] scaled;
   logic [8:0]  shift_n;
   logic [EXP_TABLE_BITS-1:0] idx;
   logic [15:0] entry;
   logic [15:0] table_rom [TableDepth];

   always_comb begin
      for (int i = 0; i < TableDepth; i++) begin
         table_rom[i] = exp_entry(i, EXP_TABLE_BITS);
      end
   end

   assign prod_in = diff * Log2eQ15;
   assign scaled  = prod_ff[31:7];
   assign shift_n = scaled[24:16];
   assign idx     = scaled[15 -: EXP_TABLE_BITS];
   assign entry   = table_rom[idx];
   assign exp_in  = (shift_n >= 9'd16) ? 16'd0 : (entry >> shift_n[3:0]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      exp_ff  <= exp_in;
   end

   assign exp_q15 = exp_ff;
endmodule

[hw/rtl/smx_div.sv]
// ----------------------------------------------------------------------------
// smx_div: restoring divider
// Computes (num*65536 + sum/2) / sum one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module smx_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] numer,
   input  logic [21:0] denom,
   output logic        done,
   output logic [15:0] quot
);
   import smx_pkg::*;

   // Dividend is at most 2^32 + 2^21, so 33 quotient bits cover it.
   logic [32:0] dvd_ff, dvd_in;
   logic [22:0] rem_ff, rem_in;
   logic [32:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [22:0] trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[21:0], dvd_ff[32]};
      if (start) begin
         dvd_in  = {1'b0, numer, 16'd0} + {12'd0, denom[21:1]};
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[31:0], 1'b0};
         if (trial >= {1'b0, denom}) begin
            rem_in = trial - {1'b0, denom};
            q_in   = {q_ff[31:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (q_ff[32:16] != 17'd0) ? 16'hFFFF : q_ff[15:0];
endmodule

[hw/rtl/smx_checker.sv]
// ----------------------------------------------------------------------------
// smx_checker: port-level checks
// Observes the softmax ports over time.
// ----------------------------------------------------------------------------
module smx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   // A result is never offered while the request side is ready.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready)) else $error("request taken during output");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tlast)) else $error("stalled result changed");

   // The last result of a vector reopens the request side.
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("input not reopened after final result");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result after reset");
endmodule

bind softmax_vector smx_checker u_smx_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

[bench/softmax_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_checker: result predictor and comparator for softmax_vector
// Watches both streams, computes the expected probabilities of each closed
// vector and compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module softmax_checker #(
   parameter int unsigned VEC_MAX        = 64,
   parameter int unsigned EXP_TABLE_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          failures,
   output int          pending,
   output int          results_seen,
   output int          vectors_seen
);
   import smx_pkg::*;

   typedef struct packed {
      logic [15:0] probability;
      logic        final_flag;
   } prob_item_t;

   prob_item_t        prob_queue[$];
   logic signed [15:0] elems[$];
   logic signed [15:0] vec_peak;

   // 2^(-idx/2^EXP_TABLE_BITS) in Q1.15, built by repeated root products in Q2.30.
   function automatic logic [15:0] root_product(input int unsigned idx);
      logic [63:0] acc;
      acc = 64'd1 << 30;
      for (int b = EXP_TABLE_BITS - 1; b >= 0; b--) begin
         if (idx[b]) acc = (acc * RootQ30[EXP_TABLE_BITS - b] + (64'd1 << 29)) >> 30;
      end
      return 16'((acc + 64'd16384) >> 15);
   endfunction

   function automatic logic [15:0] shifted_exp(input logic signed [15:0] peak,
                                               input logic signed [15:0] x);
      logic [15:0] d;
      logic [31:0] y;
      d = 16'(peak - x);
      y = 32'(({48'd0, d} * 64'd47274) >> 7);
      if (y[31:16] >= 16) return 16'd0;
      return root_product(int'(y[15:0] >> (16 - EXP_TABLE_BITS))) >> y[31:16];
   endfunction

   task automatic predict_vector();
      logic [15:0] ex[$];
      logic [21:0] total;
      logic [63:0] p;
      total = '0;
      foreach (elems[i]) begin
         ex.push_back(shifted_exp(vec_peak, elems[i]));
         total = total + ex[i];
      end
      foreach (ex[i]) begin
         p = 0;
         if (total != 0) begin
            p = (({48'd0, ex[i]} << 16) + (total >> 1)) / total;
            if (p > 65535) p = 65535;
         end
         prob_queue.push_back('{16'(p), i == ex.size() - 1});
      end
      elems.delete();
      vec_peak = -16'sd32768;
   endtask

   always @(posedge clock) begin
      prob_item_t want;
      int errs;
      errs = 0;
      if (reset) begin
         failures <= 0;
         results_seen <= 0;
         vectors_seen <= 0;
         prob_queue.delete();
         elems.delete();
         vec_peak = -16'sd32768;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (prob_queue.size() == 0) begin
               $error("unexpected result probability=%0d", rsp_tdata);
               errs++;
            end else begin
               want = prob_queue.pop_front();
               if (want.probability !== rsp_tdata) begin
                  $error("probability expected %0d actual %0d", want.probability, rsp_tdata);
                  errs++;
               end
               if (want.final_flag !== rsp_tlast) begin
                  $error("final_flag expected %0d actual %0d", want.final_flag, rsp_tlast);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            // Elements past the vector capacity are dropped entirely.
            if (elems.size() < VEC_MAX) begin
               elems.push_back(req_tdata);
               if ($signed(req_tdata) > vec_peak) vec_peak = req_tdata;
            end
            if (req_tlast) begin
               predict_vector();
               vectors_seen <= vectors_seen + 1;
            end
         end
         if (errs != 0) failures <= failures + errs;
      end
      pending = prob_queue.size();
   end
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for softmax_vector
// Streams directed and random vectors with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   int          failures, pending, results_seen, vectors_seen;
   int          cycle_count = 0;
   int          sent;
   bit          calm;

   softmax_vector dut (.*);

   softmax_checker watcher (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Generous run-length limit: a run past it is reported as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Result side back-pressure, off during the calm stretch.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= calm || ($urandom_range(99) >= 37);
   end

   task automatic send_request(input logic [15:0] v, input logic last);
      while (!calm && $urandom_range(99) < 37) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= v;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_vector(input int len, input int mode);
      logic [15:0] v;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(2047)) - 16'd1024;
            default: v = (i % 2) ? 16'h7FFF : 16'h8000;
         endcase
         send_request(v, i == len - 1);
      end
   endtask

   initial begin
      sent = 0;
      calm = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: single element, extremes, equal values, overlong vector.
      send_request(16'h8000, 1);
      send_request(16'h7FFF, 1);
      send_request(16'h0000, 0);
      send_request(16'h0000, 1);
      send_vector(4, 2);
      send_request(16'h0100, 0);
      send_request(16'h0000, 0);
      send_request(16'hFF00, 1);
      send_vector(66, 0);
      // Random: mostly short vectors, a calm stretch, a few full ones.
      while (sent < 330) begin
         calm = (sent > 200 && sent < 260);
         if ($urandom_range(9) == 0) send_vector(64 + $urandom_range(3), $urandom_range(1));
         else send_vector($urandom_range(1, 8), $urandom_range(2) == 0 ? 0 : 1);
      end
      req_tvalid <= 0;
      calm = 0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d elements in %0d vectors; checked %0d probabilities.",
               sent, vectors_seen, results_seen);
      if (failures == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
